// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LEA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LEA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lea_pkg.sv =====
// ---------------------------------------------------------------------------
// LEA package
// Types, constants and helper functions shared by the LEA cipher modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lea_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned RND_W      = 6;
  localparam int unsigned ROW_WORDS  = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // Configuration register indices.
  localparam logic [CFG_IDX_W-1:0] REG_KEY_01  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_23  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_45  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_67  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN = 3'd4;

  // Key length codes; the unused code is handled as a 256-bit key.
  localparam logic [1:0] KEYLEN_128 = 2'd0;
  localparam logic [1:0] KEYLEN_192 = 2'd1;

  // Nominal round counts per key length.
  localparam logic [RND_W-1:0] ROUNDS_128 = 6'd24;
  localparam logic [RND_W-1:0] ROUNDS_192 = 6'd28;
  localparam logic [RND_W-1:0] ROUNDS_256 = 6'd32;

  // Decryption round phases, one word of the round per phase.
  localparam logic [1:0] DEC_PH_FIRST = 2'd0;
  localparam logic [1:0] DEC_PH_MID   = 2'd1;
  localparam logic [1:0] DEC_PH_LAST  = 2'd2;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [ROW_WORDS-1:0] rk_row_t;
  typedef word_t [3:0] blk_t;

  // Key schedule constants.
  localparam word_t DELTA [8] = '{
    32'hc3efe9db, 32'h44626b02, 32'h79e27c8a, 32'h78df30ec,
    32'h715ea49e, 32'hc785da0a, 32'he04ef22a, 32'he5c40957
  };

  localparam logic [4:0] KS_ROT [6] = '{5'd1, 5'd3, 5'd6, 5'd11, 5'd13, 5'd17};

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_FETCH,
    ST_RUN,
    ST_DONE
  } lea_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             in_load;
    logic             ks_load;
    logic             ks_step;
    logic             enc_step;
    logic             dec_step;
    logic [1:0]       dec_phase;
    logic [RND_W-1:0] rnd;
    logic [RND_W-1:0] rd_row;
    logic             out_load;
  } lea_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       cfg_wr;
    logic       act;
    logic [1:0] key_len;
  } lea_stat_t;

  // Rotate a word left by a variable amount.
  function automatic word_t rol32(word_t x, logic [4:0] n);
    logic [2*WORD_W-1:0] dbl;
    dbl = {x, x} << n;
    return dbl[2*WORD_W-1:WORD_W];
  endfunction

endpackage

// ===== hdl/lea_if.sv =====
// ---------------------------------------------------------------------------
// LEA stream interfaces
// Valid/ready channels for input blocks and result blocks.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lea_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] block_word_0;
  logic [31:0] block_word_1;
  logic [31:0] block_word_2;
  logic [31:0] block_word_3;

  modport source (
    output valid, action, block_word_0, block_word_1, block_word_2, block_word_3,
    input  ready
  );
  modport sink (
    input  valid, action, block_word_0, block_word_1, block_word_2, block_word_3,
    output ready
  );
endinterface

interface lea_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_word_0;
  logic [31:0] result_word_1;
  logic [31:0] result_word_2;
  logic [31:0] result_word_3;

  modport source (
    output valid, result_word_0, result_word_1, result_word_2, result_word_3,
    input  ready
  );
  modport sink (
    input  valid, result_word_0, result_word_1, result_word_2, result_word_3,
    output ready
  );
endinterface

// ===== hdl/lea_dp.sv =====
// ---------------------------------------------------------------------------
// LEA datapath
// Key registers, key schedule, round key memory, round logic and result
// register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lea_dp #(
  parameter int unsigned MAX_ROUNDS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lea_pkg::CFG_IDX_W-1:0]        cfg_addr_i,
  input  logic [lea_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                 action_i,
  input  lea_pkg::blk_t                        in_blk_i,
  input  lea_pkg::lea_cmd_t                    cmd_i,
  output lea_pkg::lea_stat_t                   stat_o,
  output lea_pkg::blk_t                        out_blk_o
);
  import lea_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ROUNDS);

  word_t [7:0] key_q;
  logic [1:0]  key_len_q;
  logic        cfg_hit;

  word_t       t_q [8];
  word_t       t_d [8];
  logic [2:0]  base_q;
  logic [2:0]  d6_q;
  word_t       d_sel;
  logic [2:0]  src_idx [ROW_WORDS];
  logic [2:0]  off_w   [8];
  word_t       nv      [ROW_WORDS];
  rk_row_t     row_w;
  logic        wide;
  logic        narrow;

  rk_row_t     rk_mem [MAX_ROUNDS];
  rk_row_t     rk_q;

  blk_t        x_q;
  blk_t        x_d;
  logic        act_q;
  blk_t        out_q;

  word_t       sub_a;
  word_t       sub_b;
  word_t       sub_m;
  word_t       sub_r;

  // Configuration register file; any listed register marks the schedule stale.
  assign cfg_hit = cfg_we_i && (cfg_addr_i <= REG_KEY_LEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q     <= '0;
      key_len_q <= KEYLEN_128;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_KEY_01:  key_q[1:0] <= cfg_wdata_i;
        REG_KEY_23:  key_q[3:2] <= cfg_wdata_i;
        REG_KEY_45:  key_q[5:4] <= cfg_wdata_i;
        REG_KEY_67:  key_q[7:6] <= cfg_wdata_i;
        REG_KEY_LEN: key_len_q  <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  assign stat_o.cfg_wr  = cfg_hit;
  assign stat_o.act     = act_q;
  assign stat_o.key_len = key_len_q;

  // One key schedule round per cycle. For 256-bit keys the six words of a
  // round walk round the eight-word state, starting at 6*round mod 8.
  assign narrow = (key_len_q == KEYLEN_128);
  assign wide   = key_len_q[1];

  always_comb begin
    if (narrow) begin
      d_sel = DELTA[cmd_i.rnd[1:0]];
    end else if (key_len_q == KEYLEN_192) begin
      d_sel = DELTA[d6_q];
    end else begin
      d_sel = DELTA[cmd_i.rnd[2:0]];
    end

    for (int k = 0; k < ROW_WORDS; k++) begin
      src_idx[k] = wide ? (base_q + 3'(k)) : 3'(k);
      nv[k] = rol32(t_q[src_idx[k]] + rol32(d_sel, cmd_i.rnd[4:0] + 5'(k)), KS_ROT[k]);
    end

    for (int j = 0; j < 8; j++) begin
      off_w[j] = 3'(j) - base_q;
      t_d[j]   = t_q[j];
      if (wide) begin
        if (off_w[j] < 3'(ROW_WORDS)) begin
          t_d[j] = nv[off_w[j]];
        end
      end else if (narrow) begin
        if (j < 4) begin
          t_d[j] = nv[j];
        end
      end else if (j < ROW_WORDS) begin
        t_d[j] = nv[j];
      end
    end

    if (narrow) begin
      row_w[0] = nv[0];
      row_w[1] = nv[1];
      row_w[2] = nv[2];
      row_w[3] = nv[1];
      row_w[4] = nv[3];
      row_w[5] = nv[1];
    end else begin
      for (int k = 0; k < ROW_WORDS; k++) begin
        row_w[k] = nv[k];
      end
    end
  end

  // Key schedule state.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ks_load) begin
      for (int j = 0; j < 8; j++) begin
        t_q[j] <= key_q[j];
      end
      base_q <= '0;
      d6_q   <= '0;
    end else if (cmd_i.ks_step) begin
      t_q    <= t_d;
      base_q <= base_q + 3'd6;
      d6_q   <= (d6_q == 3'd5) ? 3'd0 : d6_q + 3'd1;
    end
  end

  // Round key memory: one row of six words per round, registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ks_step) begin
      rk_mem[cmd_i.rnd[AW-1:0]] <= row_w;
    end
    rk_q <= rk_mem[cmd_i.rd_row[AW-1:0]];
  end

  // Decryption works one word per phase through a shared subtractor.
  always_comb begin
    unique case (cmd_i.dec_phase)
      DEC_PH_FIRST: begin
        sub_a = rol32(x_q[0], 5'd23);
        sub_b = x_q[3] ^ rk_q[0];
        sub_m = rk_q[1];
      end
      DEC_PH_MID: begin
        sub_a = rol32(x_q[1], 5'd5);
        sub_b = x_q[0] ^ rk_q[2];
        sub_m = rk_q[3];
      end
      default: begin
        sub_a = rol32(x_q[2], 5'd3);
        sub_b = x_q[1] ^ rk_q[4];
        sub_m = rk_q[5];
      end
    endcase
    sub_r = (sub_a - sub_b) ^ sub_m;
  end

  // Next block state for an encryption round or a decryption phase.
  always_comb begin
    x_d = x_q;
    if (cmd_i.enc_step) begin
      x_d[0] = rol32((x_q[0] ^ rk_q[0]) + (x_q[1] ^ rk_q[1]), 5'd9);
      x_d[1] = rol32((x_q[1] ^ rk_q[2]) + (x_q[2] ^ rk_q[3]), 5'd27);
      x_d[2] = rol32((x_q[2] ^ rk_q[4]) + (x_q[3] ^ rk_q[5]), 5'd29);
      x_d[3] = x_q[0];
    end else if (cmd_i.dec_step) begin
      unique case (cmd_i.dec_phase)
        DEC_PH_FIRST: x_d[0] = sub_r;
        DEC_PH_MID:   x_d[1] = sub_r;
        default: begin
          x_d[0] = x_q[3];
          x_d[1] = x_q[0];
          x_d[2] = x_q[1];
          x_d[3] = sub_r;
        end
      endcase
    end
  end

  // Block state and result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      x_q   <= in_blk_i;
      act_q <= action_i;
    end else begin
      x_q <= x_d;
    end
    if (cmd_i.out_load) begin
      out_q <= x_q;
    end
  end

  assign out_blk_o = out_q;

endmodule

// ===== hdl/lea_ctrl.sv =====
// ---------------------------------------------------------------------------
// LEA controller
// Sequences key expansion, round iteration and result hand-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lea_ctrl #(
  parameter int unsigned MAX_ROUNDS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  lea_pkg::lea_stat_t  stat_i,
  output lea_pkg::lea_cmd_t   cmd_o
);
  import lea_pkg::*;

  localparam logic [RND_W-1:0] MAX_R = RND_W'(MAX_ROUNDS);

  lea_state_e       state_q, state_d;
  logic [RND_W-1:0] rnd_q, rnd_d;
  logic [1:0]       phase_q, phase_d;
  logic [RND_W-1:0] rounds_q, rounds_d;
  logic             sched_q, sched_d;
  logic             out_valid_q, out_valid_d;
  logic [RND_W-1:0] nominal;
  logic [RND_W-1:0] limit;
  logic [RND_W-1:0] next_lr;
  logic             adv;

  // Round count for the configured key length, capped at the store depth.
  always_comb begin
    unique case (stat_i.key_len)
      KEYLEN_128: nominal = ROUNDS_128;
      KEYLEN_192: nominal = ROUNDS_192;
      default:    nominal = ROUNDS_256;
    endcase
    limit = (nominal < MAX_R) ? nominal : MAX_R;
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rnd_q       <= '0;
      phase_q     <= DEC_PH_FIRST;
      rounds_q    <= ROUNDS_128;
      sched_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      phase_q     <= phase_d;
      rounds_q    <= rounds_d;
      sched_q     <= sched_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d     = state_q;
    rnd_d       = rnd_q;
    phase_d     = phase_q;
    rounds_d    = rounds_q;
    sched_d     = sched_q && !stat_i.cfg_wr;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    next_lr     = rnd_q;
    adv         = 1'b0;
    cmd_o       = '0;
    cmd_o.rnd       = rnd_q;
    cmd_o.dec_phase = phase_q;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          rnd_d         = '0;
          phase_d       = DEC_PH_FIRST;
          if (!sched_q) begin
            cmd_o.ks_load = 1'b1;
            rounds_d      = limit;
            state_d       = ST_EXPAND;
          end else begin
            state_d = ST_FETCH;
          end
        end
      end

      ST_EXPAND: begin
        cmd_o.ks_step = 1'b1;
        if (rnd_q == rounds_q - 1'b1) begin
          rnd_d   = '0;
          sched_d = 1'b1;
          state_d = ST_FETCH;
        end else begin
          rnd_d = rnd_q + 1'b1;
        end
      end

      ST_FETCH: begin
        next_lr = '0;
        state_d = ST_RUN;
      end

      ST_RUN: begin
        if (stat_i.act) begin
          cmd_o.dec_step = 1'b1;
          adv            = (phase_q == DEC_PH_LAST);
          phase_d        = adv ? DEC_PH_FIRST : phase_q + 2'd1;
        end else begin
          cmd_o.enc_step = 1'b1;
          adv            = 1'b1;
        end
        if (adv) begin
          next_lr = rnd_q + 1'b1;
          if (rnd_q == rounds_q - 1'b1) begin
            rnd_d   = '0;
            state_d = ST_DONE;
          end else begin
            rnd_d = rnd_q + 1'b1;
          end
        end
      end

      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Decryption walks the round key rows backwards.
    cmd_o.rd_row = stat_i.act ? (rounds_q - 1'b1 - next_lr) : next_lr;
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/lea_block_cipher.sv =====
// An accepted block fetches its first round key row, runs n rounds (three phases
// each when decrypting) and is loaded into the result register, where n is 24, 28
// or 32 rounds by key length. A block that finds the key schedule stale first waits
// while it is expanded. The single round unit takes no new block until the last
// result is loaded; decryption uses one shared subtractor over three phases.
// Reset clears keys, key length and control; the round key memory is not cleared.
// ---------------------------------------------------------------------------
// LEA block cipher
// 128-bit block LEA engine with 128/192/256-bit keys held in configuration.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lea_block_cipher #(
  parameter int unsigned MAX_ROUNDS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lea_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [lea_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  lea_in_if.sink                         in_if,
  lea_out_if.source                      out_if
);
  import lea_pkg::*;

  lea_cmd_t  cmd;
  lea_stat_t stat;
  blk_t      in_blk;
  blk_t      out_blk;
  logic      in_ready;
  logic      out_valid;

  assign in_blk = {in_if.block_word_3, in_if.block_word_2,
                   in_if.block_word_1, in_if.block_word_0};

  // Controller.
  lea_ctrl #(
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_if.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath.
  lea_dp #(
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .action_i    (in_if.action),
    .in_blk_i    (in_blk),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_blk_o   (out_blk)
  );

  // Channel outputs.
  assign in_if.ready          = in_ready;
  assign out_if.valid         = out_valid;
  assign out_if.result_word_0 = out_blk[0];
  assign out_if.result_word_1 = out_blk[1];
  assign out_if.result_word_2 = out_blk[2];
  assign out_if.result_word_3 = out_blk[3];

  // Checks on the controller and datapath interplay.
  `LEA_ASSERT_NOW(a_no_result_overwrite, cmd.out_load && out_if.valid, out_if.ready, "beat lost")
  `LEA_ASSERT_NEXT(a_no_instant_result, in_if.valid && in_if.ready, !cmd.out_load, "early result")
  `LEA_ASSERT_NOW(a_expand_exclusive, cmd.ks_step,
                  !in_if.ready && !cmd.enc_step && !cmd.dec_step, "expansion overlaps block work")
  `LEA_ASSERT_NOW(a_one_command, 1'b1,
                  $onehot0({cmd.in_load, cmd.ks_step, cmd.enc_step, cmd.dec_step, cmd.out_load}),
                  "more than one datapath command at once")

endmodule

// ===== sim/tb_lea_block_cipher.sv =====
// ---------------------------------------------------------------------------
// LEA block cipher testbench
// Drives encrypt and decrypt beats through the cipher under 128-, 192- and
// 256-bit keys (and the spare key length code). Each result is checked word
// by word against a typed expectation or an in-bench model of the key schedule
// and the rounds. A directed table comes first, then randomised segments,
// most under a fresh key set while idle, with round-trip decrypts mixed in.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lea_block_cipher;
  import lea_pkg::*;

  localparam int unsigned CLK_PERIOD  = 10;
  localparam int unsigned RESET_CYC   = 11;
  localparam int unsigned ROUND_CAP   = 32;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // Longest decrypt plus a schedule expansion, with margin.
  localparam int unsigned TAIL_CYCLES = 200;
  localparam int unsigned SEGMENTS    = 30;
  localparam int unsigned SEG_BEATS   = 25;

  localparam logic [1:0] KEYLEN_256   = 2'd2;
  localparam logic [1:0] KEYLEN_SPARE = 2'd3;

  // Indices past the register list; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [CFG_IDX_W-1:0] KEY_REGS [4] = '{
    REG_KEY_01, REG_KEY_23, REG_KEY_45, REG_KEY_67
  };

  localparam logic [31:0] SCHED_DELTA [8] = '{
    32'hc3efe9db, 32'h44626b02, 32'h79e27c8a, 32'h78df30ec,
    32'h715ea49e, 32'hc785da0a, 32'he04ef22a, 32'he5c40957
  };
  localparam int unsigned SCHED_ROT [6] = '{1, 3, 6, 11, 13, 17};

  typedef enum logic {
    ACT_ENCRYPT = 1'b0,
    ACT_DECRYPT = 1'b1
  } action_e;

  typedef enum int unsigned {
    IDLE_SENDER_LIGHT,
    IDLE_SENDER_HEAVY,
    IDLE_NONE
  } idle_mode_e;

  // Word 0 of the block sits in bits 31..0.
  typedef logic [3:0][31:0] quad_t;

  typedef struct packed {
    action_e act;
    quad_t   words;
  } cipher_beat_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    cipher_beat_t          beat;
    logic                  has_exp;
    quad_t                 exp_words;
  } stim_row_t;

  // Directed table: register writes and blocks. A typed expectation is given
  // only for the published 128-bit known-answer pair.
  localparam int unsigned DIR_ROWS = 36;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    // Reset key: all-zero 128-bit key, schedule still to be expanded.
    '{1'b0, '0, '0, '{ACT_ENCRYPT, 128'h0}, 1'b0, '0},
    '{1'b0, '0, '0, '{ACT_ENCRYPT, {128{1'b1}}}, 1'b0, '0},
    '{1'b0, '0, '0, '{ACT_DECRYPT, {128{1'b1}}}, 1'b0, '0},
    '{1'b0, '0, '0, '{ACT_DECRYPT, 128'h0}, 1'b0, '0},
    // Known-answer 128-bit key, then encrypt and decrypt back.
    '{1'b1, REG_KEY_01, 64'h78695a4b_3c2d1e0f, '{ACT_ENCRYPT, 128'h0}, 1'b0, '0},
    '{1'b1, REG_KEY_23, 64'hf0e1d2c3_b4a59687, '{ACT_ENCRYPT, 128'h0}, 1'b0, '0},
    '{1'b1, REG_KEY_LEN, 64'(KEYLEN_128), '{ACT_ENCRYPT, 128'h0}, 1'b0, '0},
    '{1'b0, '0, '0, '{ACT_ENCRYPT, 128'h1f1e1d1c_1b1a1918_17161514_13121110},
      1'b1, 128'hfd8b6404_a7c73255_18c6c628_354ec89f},
    '{1'b0, '0, '0, '{ACT_DECRYPT, 128'hfd8b6404_a7c73255_18c6c628_354ec89f},
      1'b1, 128'h1f1e1d1c_1b1a1918_17161514_13121110},
    // 192-bit key.
    '{1'b1, REG_KEY_45, {64{1'b1}}, '{ACT_ENCRYPT, 128'h0}, 1'b0, '0},
    '{1'b1, REG_KEY_LEN, 64'(KEYLEN_192), '{ACT_ENCRYPT, 128'h0}, 1'b0, '0},
    '{1'b0, '0, '0, '{ACT_ENCRYPT, {128{1'b1}}}, 1'b0, '0},
    '{1'b0, '0, '0, '{ACT_DECRYPT, 128'h89abcdef_01234567_fedcba98_76543210},
      1'b0, '0},
    // 256-bit key.
    '{1'b1, REG_KEY_67, 64'h80000000_00000001, '{ACT_ENCRYPT, 128'h0}, 1'b0, '0},
    '{1'b1, REG_KEY_LEN, 64'(KEYLEN_256), '{ACT_ENCRYPT, 128'h0}, 1'b0, '0},
    '{1'b0, '0, '0, '{ACT_ENCRYPT, 128'h80000000_00000001_80000000_00000001},
      1'b0, '0},
    '{1'b0, '0, '0, '{ACT_DECRYPT, 128'h80000000_00000001_80000000_00000001},
      1'b0, '0},
    // The spare length code behaves as a 256-bit key.
    '{1'b1, REG_KEY_LEN, 64'(KEYLEN_SPARE), '{ACT_ENCRYPT, 128'h0}, 1'b0, '0},
    '{1'b0, '0, '0, '{ACT_ENCRYPT, 128'h0}, 1'b0, '0},
    '{1'b0, '0, '0, '{ACT_DECRYPT, 128'h55555555_aaaaaaaa_55555555_aaaaaaaa},
      1'b0, '0},
    // Writes beyond the register list change nothing.
    '{1'b1, REG_SPARE_LO, {64{1'b1}}, '{ACT_ENCRYPT, 128'h0}, 1'b0, '0},
    '{1'b1, REG_SPARE_HI, {64{1'b1}}, '{ACT_ENCRYPT, 128'h0}, 1'b0, '0},
    '{1'b0, '0, '0, '{ACT_ENCRYPT, 128'h01234567_89abcdef_76543210_fedcba98},
      1'b0, '0},
    // All-ones 256-bit key.
    '{1'b1, REG_KEY_01, {64{1'b1}}, '{ACT_ENCRYPT, 128'h0}, 1'b0, '0},
    '{1'b1, REG_KEY_23, {64{1'b1}}, '{ACT_ENCRYPT, 128'h0}, 1'b0, '0},
    '{1'b1, REG_KEY_45, {64{1'b1}}, '{ACT_ENCRYPT, 128'h0}, 1'b0, '0},
    '{1'b1, REG_KEY_67, {64{1'b1}}, '{ACT_ENCRYPT, 128'h0}, 1'b0, '0},
    '{1'b1, REG_KEY_LEN, 64'(KEYLEN_256), '{ACT_ENCRYPT, 128'h0}, 1'b0, '0},
    '{1'b0, '0, '0, '{ACT_ENCRYPT, {128{1'b1}}}, 1'b0, '0},
    '{1'b0, '0, '0, '{ACT_DECRYPT, {128{1'b1}}}, 1'b0, '0},
    '{1'b0, '0, '0, '{ACT_ENCRYPT, 128'h0}, 1'b0, '0},
    // Back to an all-zero 128-bit key.
    '{1'b1, REG_KEY_01, 64'h0, '{ACT_ENCRYPT, 128'h0}, 1'b0, '0},
    '{1'b1, REG_KEY_23, 64'h0, '{ACT_ENCRYPT, 128'h0}, 1'b0, '0},
    '{1'b1, REG_KEY_LEN, 64'(KEYLEN_128), '{ACT_ENCRYPT, 128'h0}, 1'b0, '0},
    '{1'b0, '0, '0, '{ACT_ENCRYPT, 128'h0}, 1'b0, '0},
    '{1'b0, '0, '0, '{ACT_DECRYPT, 128'h0}, 1'b0, '0}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  lea_in_if  in_ch ();
  lea_out_if out_ch ();

  lea_block_cipher #(
    .MAX_ROUNDS (ROUND_CAP)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  // Model copy of the configuration and of the key schedule.
  logic [63:0] model_key [4];
  logic [1:0]  model_key_len;
  logic [31:0] sched [6*ROUND_CAP];
  int unsigned sched_rounds;
  bit          sched_stale;

  quad_t       expected_results [$];
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned checked_count;
  int unsigned enc_sent;
  int unsigned dec_sent;
  int unsigned rekey_count;

  always #(CLK_PERIOD/2) clk_i = ~clk_i;

  function automatic logic [31:0] spin_left(logic [31:0] x, int unsigned n);
    n = n % 32;
    if (n == 0) return x;
    return (x << n) | (x >> (32 - n));
  endfunction

  // Expand the current key into round keys, as the block does on the first
  // beat after reset or after a write to a listed register.
  function automatic void expand_schedule();
    logic [31:0] t [8];
    logic [31:0] d;
    int unsigned nominal;
    int unsigned w;
    for (int j = 0; j < 4; j++) begin
      t[2*j]   = model_key[j][31:0];
      t[2*j+1] = model_key[j][63:32];
    end
    if (model_key_len == KEYLEN_128) begin
      nominal = ROUNDS_128;
    end else if (model_key_len == KEYLEN_192) begin
      nominal = ROUNDS_192;
    end else begin
      nominal = ROUNDS_256;
    end
    if (nominal > ROUND_CAP) nominal = ROUND_CAP;
    for (int unsigned i = 0; i < nominal; i++) begin
      if (model_key_len == KEYLEN_128) begin
        d = SCHED_DELTA[i % 4];
        for (int unsigned k = 0; k < 4; k++) begin
          t[k] = spin_left(t[k] + spin_left(d, i + k), SCHED_ROT[k]);
        end
        sched[6*i]   = t[0];
        sched[6*i+1] = t[1];
        sched[6*i+2] = t[2];
        sched[6*i+3] = t[1];
        sched[6*i+4] = t[3];
        sched[6*i+5] = t[1];
      end else if (model_key_len == KEYLEN_192) begin
        d = SCHED_DELTA[i % 6];
        for (int unsigned k = 0; k < 6; k++) begin
          t[k] = spin_left(t[k] + spin_left(d, i + k), SCHED_ROT[k]);
          sched[6*i+k] = t[k];
        end
      end else begin
        d = SCHED_DELTA[i % 8];
        for (int unsigned k = 0; k < 6; k++) begin
          w    = (6*i + k) % 8;
          t[w] = spin_left(t[w] + spin_left(d, i + k), SCHED_ROT[k]);
          sched[6*i+k] = t[w];
        end
      end
    end
    sched_rounds = nominal;
    sched_stale  = 1'b0;
  endfunction

  // Result of one block under the current key.
  function automatic quad_t cipher_predict(cipher_beat_t beat);
    quad_t       x;
    logic [31:0] y0, y1, y2, y3;
    int unsigned b;
    if (sched_stale) expand_schedule();
    x = beat.words;
    if (beat.act == ACT_ENCRYPT) begin
      for (int unsigned r = 0; r < sched_rounds; r++) begin
        b  = 6*r;
        y0 = spin_left((x[0] ^ sched[b])   + (x[1] ^ sched[b+1]), 9);
        // Right rotations by 5 and 3 written as left rotations.
        y1 = spin_left((x[1] ^ sched[b+2]) + (x[2] ^ sched[b+3]), 27);
        y2 = spin_left((x[2] ^ sched[b+4]) + (x[3] ^ sched[b+5]), 29);
        x  = {x[0], y2, y1, y0};
      end
    end else begin
      for (int unsigned r = 0; r < sched_rounds; r++) begin
        b  = 6*(sched_rounds - 1 - r);
        y0 = x[3];
        y1 = (spin_left(x[0], 23) - (y0 ^ sched[b]))   ^ sched[b+1];
        y2 = (spin_left(x[1], 5)  - (y1 ^ sched[b+2])) ^ sched[b+3];
        y3 = (spin_left(x[2], 3)  - (y2 ^ sched[b+4])) ^ sched[b+5];
        x  = {y3, y2, y1, y0};
      end
    end
    return x;
  endfunction

  function automatic void set_idle_mode(idle_mode_e mode);
    case (mode)
      IDLE_SENDER_LIGHT: begin
        tx_idle_pct = 11;
        rx_idle_pct = 79;
      end
      IDLE_SENDER_HEAVY: begin
        tx_idle_pct = 79;
        rx_idle_pct = 11;
      end
      default: begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0;
      1:       return 32'hffffffff;
      default: return $urandom;
    endcase
  endfunction

  // One register write; only called while nothing is outstanding.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    bit listed;
    listed = 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_KEY_01:  model_key[0] = data;
      REG_KEY_23:  model_key[1] = data;
      REG_KEY_45:  model_key[2] = data;
      REG_KEY_67:  model_key[3] = data;
      REG_KEY_LEN: model_key_len = data[1:0];
      default:     listed = 1'b0;
    endcase
    if (listed) sched_stale = 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Present one beat, with random gaps ahead of it, and log its result.
  task automatic send_beat(cipher_beat_t beat, bit has_exp, quad_t exp_words,
                           output quad_t predicted);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= beat.act;
    in_ch.block_word_0 <= beat.words[0];
    in_ch.block_word_1 <= beat.words[1];
    in_ch.block_word_2 <= beat.words[2];
    in_ch.block_word_3 <= beat.words[3];
    do @(posedge clk_i); while (!in_ch.ready);
    predicted = cipher_predict(beat);
    expected_results.push_back(has_exp ? exp_words : predicted);
    if (beat.act == ACT_ENCRYPT) enc_sent++;
    else dec_sent++;
  endtask

  // Stop sending and wait for every outstanding result.
  task automatic drain_results();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // New random key and length; the key words are sometimes all zero or all
  // ones, and the length write carries random upper bits.
  task automatic rekey_random();
    int unsigned     style;
    logic [1:0]      key_len;
    logic [63:0]     data;
    style = $urandom_range(0, 3);
    for (int r = 0; r < 4; r++) begin
      if ($urandom_range(0, 3) != 0) begin
        data = (style == 0) ? 64'h0 : (style == 1) ? {64{1'b1}} : {$urandom, $urandom};
        write_reg(KEY_REGS[r], data);
      end
    end
    if ($urandom_range(0, 5) == 0) begin
      write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                {$urandom, $urandom});
    end
    key_len   = 2'($urandom_range(0, 3));
    data      = {$urandom, $urandom};
    data[1:0] = key_len;
    write_reg(REG_KEY_LEN, data);
    rekey_count++;
  endtask

  // Receiver stalls.
  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Compare each result beat with the oldest outstanding block.
  always @(posedge clk_i) begin : check_results
    quad_t got;
    quad_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = {out_ch.result_word_3, out_ch.result_word_2,
             out_ch.result_word_1, out_ch.result_word_0};
      if (expected_results.size() == 0) begin
        $error("result beat %08h_%08h_%08h_%08h with no block outstanding",
               got[3], got[2], got[1], got[0]);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        for (int w = 0; w < 4; w++) begin
          if (got[w] !== want[w]) begin
            $error("result_word_%0d: expected %08h, actual %08h", w, want[w], got[w]);
            mismatch_count++;
          end
        end
        checked_count++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    stim_row_t   row;
    quad_t       last_cipher;
    quad_t       predicted;
    cipher_beat_t beat;
    int unsigned mix;

    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_addr_i         = '0;
    cfg_wdata_i        = '0;
    in_ch.valid        = 1'b0;
    in_ch.action       = ACT_ENCRYPT;
    in_ch.block_word_0 = '0;
    in_ch.block_word_1 = '0;
    in_ch.block_word_2 = '0;
    in_ch.block_word_3 = '0;
    out_ch.ready       = 1'b0;
    for (int j = 0; j < 4; j++) model_key[j] = '0;
    model_key_len  = KEYLEN_128;
    sched_rounds   = ROUNDS_128;
    sched_stale    = 1'b1;
    cycle_count    = 0;
    mismatch_count = 0;
    checked_count  = 0;
    enc_sent       = 0;
    dec_sent       = 0;
    rekey_count    = 0;
    last_cipher    = '0;
    set_idle_mode(IDLE_SENDER_LIGHT);

    repeat (RESET_CYC) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table.
    for (int r = 0; r < DIR_ROWS; r++) begin
      row = DIRECTED[r];
      if (row.is_cfg) begin
        drain_results();
        write_reg(row.reg_idx, row.reg_data);
      end else begin
        send_beat(row.beat, row.has_exp, row.exp_words, predicted);
      end
    end

    // Random segments; the idle pattern moves through its three modes.
    for (int unsigned seg = 0; seg < SEGMENTS; seg++) begin
      set_idle_mode(idle_mode_e'(seg * 3 / SEGMENTS));
      if (seg == 0 || $urandom_range(0, 4) != 0) begin
        drain_results();
        rekey_random();
      end
      for (int unsigned n = 0; n < SEG_BEATS; n++) begin
        mix = $urandom_range(0, 9);
        if (mix < 3) begin
          // Round trip: decrypt the most recent ciphertext.
          beat.act   = ACT_DECRYPT;
          beat.words = last_cipher;
        end else begin
          beat.act   = (mix < 7) ? ACT_ENCRYPT : ACT_DECRYPT;
          beat.words = {pick_word(), pick_word(), pick_word(), pick_word()};
        end
        send_beat(beat, 1'b0, '0, predicted);
        if (beat.act == ACT_ENCRYPT) last_cipher = predicted;
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d encrypt and %0d decrypt blocks under %0d random key settings.",
             enc_sent, dec_sent, rekey_count);
    $display("Checked %0d result beats; %0d word mismatches.", checked_count,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
